// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FTPS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define FTPS_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

// File: sv/ftps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftps_pkg
// Types, codes and constants of the flow tracker / packet sizer.
// ----------------------------------------------------------------------------
package ftps_pkg;

    localparam int FLOW_ENTRIES_DEF = 1024;
    localparam int PROBE_LIMIT_DEF  = 8;

    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
    // floor(x / 1e6) == (x * RECIP_MAGIC) >> RECIP_SHIFT for 32-bit x
    localparam logic [31:0] RECIP_MAGIC = 32'h431BDE83;
    localparam int          RECIP_SHIFT = 50;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [1:0] KIND_FLOW = 2'd0;
    localparam logic [1:0] KIND_PKT  = 2'd1;
    localparam logic [1:0] KIND_FULL = 2'd2;

    localparam logic [1:0] MODE_TOTAL = 2'd0;
    localparam logic [1:0] MODE_IP    = 2'd1;
    localparam logic [1:0] MODE_L4    = 2'd2;
    localparam logic [1:0] MODE_APP   = 2'd3;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_EN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TCP_SKIP     = 3'd4;

    typedef struct packed {
        logic [31:0] ts_sec;
        logic [31:0] ts_usec;
        logic [7:0]  proto;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] l4_word0;
        logic [15:0] l4_word1;
        logic [31:0] l4_word4;
        logic [15:0] ip_total_len;
        logic [3:0]  ip_header_words;
        logic [3:0]  tcp_data_offset;
        logic        tcp_ctrl;
    } ftps_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] flow_number;
        logic [7:0]  rec_proto;
        logic [31:0] rec_src_ip;
        logic [31:0] rec_dst_ip;
        logic [15:0] rec_src_port;
        logic [15:0] rec_dst_port;
        logic [31:0] out_sec;
        logic [19:0] out_usec;
        logic [15:0] out_size;
        logic        last;
    } ftps_out_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] addrs;
        logic [39:0] proto_ports;
        logic [31:0] flow_number;
        logic [63:0] seen_time;
        logic        time_valid;
        logic [31:0] last_seq;
    } ftps_entry_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } ftps_alu_op_t;

    typedef struct packed {
        ftps_alu_op_t op;
        logic [63:0]  a;
        logic [63:0]  b;
    } ftps_alu_req_t;

    typedef struct packed {
        logic [63:0] res;
        logic        cout;
    } ftps_alu_rsp_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH_A,
        S_HASH_B,
        S_MUL,
        S_QM,
        S_USEC,
        S_SEC,
        S_PRB_RD,
        S_PRB_CHK,
        S_GAP,
        S_GAP2,
        S_SIZE,
        S_TCP_END,
        S_TCP_DEC,
        S_TCP_LIM,
        S_TCP_D1,
        S_TCP_C1,
        S_TCP_MAG,
        S_TCP_D2,
        S_TCP_C2,
        S_DECIDE,
        S_WRITE,
        S_EMIT_F,
        S_EMIT_P,
        S_EMIT_FULL
    } ftps_state_t;

endpackage

// File: sv/ftps_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftps_in_if / ftps_out_if
// Valid/ready channels carrying header requests and result records.
// ----------------------------------------------------------------------------
interface ftps_in_if import ftps_pkg::*; ();
    logic     valid;
    logic     ready;
    ftps_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ftps_out_if import ftps_pkg::*; ();
    logic      valid;
    logic      ready;
    ftps_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/ftps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftps_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ftps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/ftps_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftps_alu
// Shared 64-bit add/subtract unit; cout high on subtract means a >= b.
// ----------------------------------------------------------------------------
module ftps_alu import ftps_pkg::*; (
    input  ftps_alu_req_t req,
    output ftps_alu_rsp_t rsp
);

    logic [64:0] sum;
    logic        sub;

    always_comb
    begin
        sub = (req.op == ALU_SUB);
        sum = {1'b0, req.a} + {1'b0, (sub ? ~req.b : req.b)} + {64'd0, sub};
        rsp.res  = sum[63:0];
        rsp.cout = sum[64];
    end

endmodule

// File: sv/flow_tracker_packet_sizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_tracker_packet_sizer_unit
// Five-tuple flow table with hashed linear probing and per-packet sizing.
// ----------------------------------------------------------------------------
//  channel  dir  payload     handshake
//  in_ch    in   ftps_in_t   valid/ready, one header request per accept
//  out_ch   out  ftps_out_t  valid/ready, zero to two records per request
//  cfg      in   index/data  cfg_we, write only
//
// A request passes through hashing, timestamp conversion, table probing and,
// in TCP application mode, sequence tracking, before its records are emitted.
// After reset a clearing pass writes every table entry, with in_ch not ready.
// Results wait in an output register for out_ch.ready; no new request is taken
// until all records of the current one are taken.
// FLOW_ENTRIES must be a power of two.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flow_tracker_packet_sizer_unit import ftps_pkg::*; #(
    parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF,
    parameter int PROBE_LIMIT  = PROBE_LIMIT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ftps_in_if.sink               in_ch,
    ftps_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W  = $clog2(FLOW_ENTRIES);
    localparam int PCNT_W = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
    localparam int ENT_W  = $bits(ftps_entry_t);

    ftps_state_t state_reg, state_next;

    logic [1:0]  size_mode_reg;
    logic [15:0] min_size_reg;
    logic        timeout_en_reg;
    logic [47:0] max_interval_reg;
    logic [30:0] tcp_skip_reg;
    logic [31:0] next_flow_reg;
    logic [IDX_W-1:0] clr_cnt_reg;

    ftps_in_t    in_reg;
    logic [31:0] hash_reg, tmp_reg;
    logic [1:0]  hcnt_reg;
    logic [51:0] prod_reg;
    logic [63:0] recip_reg;
    logic [33:0] qm_reg;
    logic [63:0] now_reg, diff_reg;
    logic        gt_reg;
    logic [31:0] sec_reg;
    logic [19:0] usec_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [PCNT_W-1:0] pcnt_reg;
    ftps_entry_t ent_reg;
    logic        newflow_reg, pkt_reg, ok_reg;
    logic [15:0] size_reg;
    logic [31:0] endb_reg, lim_reg, d_reg, mag_reg;
    ftps_out_t   out_reg;

    ftps_alu_req_t alu_req;
    ftps_alu_rsp_t alu_rsp;

    logic        ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr;
    ftps_entry_t ram_wdata, ram_rdata;

    logic        ported;
    logic [15:0] sp, dp;
    logic [63:0] key_addrs;
    logic [39:0] key_pp;
    logic [31:0] hash_word;
    logic [13:0] q;
    logic [15:0] size_base, ihl4, hl_tcp;
    logic        ok_base, key_hit, tcp_app;
    logic [4:0]  hl_sum;
    logic        load_flow, load_pkt, load_full;

    ftps_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    ftps_ram #(
        .WIDTH (ENT_W),
        .DEPTH (FLOW_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // key and size decode
    always_comb
    begin
        ported    = (in_reg.proto == PROTO_TCP) || (in_reg.proto == PROTO_UDP);
        sp        = in_reg.l4_word0;
        dp        = ported ? in_reg.l4_word1 : in_reg.l4_word0;
        key_addrs = {in_reg.src_ip, in_reg.dst_ip};
        key_pp    = {in_reg.proto, sp, dp};
        key_hit   = (ram_rdata.addrs == key_addrs) && (ram_rdata.proto_ports == key_pp);
        q         = recip_reg[63:RECIP_SHIFT];
        tcp_app   = (size_mode_reg == MODE_APP) && (in_reg.proto == PROTO_TCP);
        case (hcnt_reg)
            2'd0:    hash_word = in_reg.src_ip;
            2'd1:    hash_word = {16'd0, sp};
            2'd2:    hash_word = in_reg.dst_ip;
            default: hash_word = {16'd0, dp};
        endcase
        ihl4   = {10'd0, in_reg.ip_header_words, 2'b00};
        hl_sum = {1'b0, in_reg.ip_header_words} + {1'b0, in_reg.tcp_data_offset};
        hl_tcp = {9'd0, hl_sum, 2'b00};
        ok_base = 1'b1;
        case (size_mode_reg)
            MODE_TOTAL: size_base = in_reg.ip_total_len;
            MODE_IP:    size_base = in_reg.ip_total_len - ihl4;
            default:
            begin
                if (in_reg.proto == PROTO_ICMP)
                begin
                    size_base = in_reg.ip_total_len - ihl4 - 16'd8;
                end
                else if (in_reg.proto == PROTO_UDP)
                begin
                    size_base = in_reg.l4_word4[31:16] - 16'd8;
                end
                else if (in_reg.proto == PROTO_TCP)
                begin
                    size_base = in_reg.ip_total_len - hl_tcp;
                end
                else
                begin
                    size_base = 16'd0;
                    ok_base   = 1'b0;
                end
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        alu_req.op   = ALU_ADD;
        alu_req.a    = 64'd0;
        alu_req.b    = 64'd0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = slot_reg;
        ram_wdata    = ent_reg;
        load_flow    = 1'b0;
        load_pkt     = 1'b0;
        load_full    = 1'b0;
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == IDX_W'(FLOW_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    state_next = S_HASH_A;
                end
            end
            S_HASH_A:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {32'd0, hash_reg[26:0], 5'd0};
                alu_req.b  = {32'd0, hash_reg};
                state_next = S_HASH_B;
            end
            S_HASH_B:
            begin
                alu_req.a  = {32'd0, tmp_reg};
                alu_req.b  = {32'd0, hash_word};
                state_next = (hcnt_reg == 2'd3) ? S_MUL : S_HASH_A;
            end
            S_MUL:
            begin
                state_next = S_QM;
            end
            S_QM:
            begin
                alu_req.a  = {12'd0, prod_reg};
                alu_req.b  = {32'd0, in_reg.ts_usec};
                state_next = S_USEC;
            end
            S_USEC:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {32'd0, in_reg.ts_usec};
                alu_req.b  = {30'd0, qm_reg};
                state_next = S_SEC;
            end
            S_SEC:
            begin
                alu_req.a  = {32'd0, in_reg.ts_sec};
                alu_req.b  = {50'd0, q};
                state_next = S_PRB_RD;
            end
            S_PRB_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_PRB_CHK;
            end
            S_PRB_CHK:
            begin
                if (!ram_rdata.valid)
                begin
                    state_next = S_SIZE;
                end
                else if (key_hit)
                begin
                    state_next = S_GAP;
                end
                else if (pcnt_reg == PCNT_W'(PROBE_LIMIT - 1))
                begin
                    load_full  = 1'b1;
                    state_next = S_EMIT_FULL;
                end
                else
                begin
                    state_next = S_PRB_RD;
                end
            end
            S_GAP:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = now_reg;
                alu_req.b  = ent_reg.seen_time;
                state_next = S_GAP2;
            end
            S_GAP2:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {16'd0, max_interval_reg};
                alu_req.b  = diff_reg;
                state_next = S_SIZE;
            end
            S_SIZE:
            begin
                state_next = tcp_app ? S_TCP_END : S_DECIDE;
            end
            S_TCP_END:
            begin
                alu_req.a  = {32'd0, in_reg.l4_word4};
                alu_req.b  = {48'd0, size_reg};
                state_next = S_TCP_DEC;
            end
            S_TCP_DEC:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {32'd0, endb_reg};
                alu_req.b  = {63'd0, !in_reg.tcp_ctrl};
                state_next = ent_reg.time_valid ? S_TCP_LIM : S_DECIDE;
            end
            S_TCP_LIM:
            begin
                alu_req.a  = {48'd0, size_reg};
                alu_req.b  = {33'd0, tcp_skip_reg};
                state_next = S_TCP_D1;
            end
            S_TCP_D1:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {32'd0, endb_reg};
                alu_req.b  = {32'd0, ent_reg.last_seq};
                state_next = S_TCP_C1;
            end
            S_TCP_C1:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {32'd0, lim_reg};
                alu_req.b  = {32'd0, d_reg};
                state_next = alu_rsp.cout ? S_DECIDE : S_TCP_MAG;
            end
            S_TCP_MAG:
            begin
                alu_req.op = ALU_SUB;
                alu_req.b  = {32'd0, ent_reg.last_seq};
                state_next = S_TCP_D2;
            end
            S_TCP_D2:
            begin
                alu_req.a  = {32'd0, endb_reg};
                alu_req.b  = {32'd0, mag_reg};
                state_next = S_TCP_C2;
            end
            S_TCP_C2:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {32'd0, lim_reg};
                alu_req.b  = {32'd0, d_reg};
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                ram_we = 1'b1;
                if (newflow_reg)
                begin
                    load_flow  = 1'b1;
                    state_next = S_EMIT_F;
                end
                else if (pkt_reg)
                begin
                    load_pkt   = 1'b1;
                    state_next = S_EMIT_P;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT_F:
            begin
                out_ch.valid = 1'b1;
                if (out_ch.ready)
                begin
                    if (pkt_reg)
                    begin
                        load_pkt   = 1'b1;
                        state_next = S_EMIT_P;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT_P, S_EMIT_FULL:
            begin
                out_ch.valid = 1'b1;
                if (out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_ch.data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            next_flow_reg    <= '0;
            size_mode_reg    <= MODE_TOTAL;
            min_size_reg     <= 16'd1;
            timeout_en_reg   <= 1'b0;
            max_interval_reg <= '0;
            tcp_skip_reg     <= 31'd65535;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == S_SIZE && newflow_reg)
            begin
                next_flow_reg <= next_flow_reg + 32'd1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SIZE_MODE:    size_mode_reg    <= cfg_wdata[1:0];
                    CFG_MIN_SIZE:     min_size_reg     <= cfg_wdata[15:0];
                    CFG_TIMEOUT_EN:   timeout_en_reg   <= cfg_wdata[0];
                    CFG_MAX_INTERVAL: max_interval_reg <= cfg_wdata;
                    CFG_TCP_SKIP:     tcp_skip_reg     <= cfg_wdata[30:0];
                    default:          ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                in_reg   <= in_ch.data;
                hash_reg <= {24'd0, in_ch.data.proto};
                hcnt_reg <= 2'd0;
            end
            S_HASH_A:
            begin
                tmp_reg <= alu_rsp.res[31:0];
            end
            S_HASH_B:
            begin
                hash_reg <= alu_rsp.res[31:0];
                hcnt_reg <= hcnt_reg + 2'd1;
            end
            S_MUL:
            begin
                prod_reg  <= in_reg.ts_sec * USEC_PER_SEC;
                recip_reg <= in_reg.ts_usec * RECIP_MAGIC;
                slot_reg  <= hash_reg[IDX_W-1:0];
                pcnt_reg  <= '0;
            end
            S_QM:
            begin
                qm_reg  <= q * USEC_PER_SEC;
                now_reg <= alu_rsp.res;
            end
            S_USEC:
            begin
                usec_reg <= alu_rsp.res[19:0];
            end
            S_SEC:
            begin
                sec_reg <= alu_rsp.res[31:0];
            end
            S_PRB_CHK:
            begin
                ent_reg     <= ram_rdata;
                newflow_reg <= !ram_rdata.valid;
                pcnt_reg    <= pcnt_reg + 1'b1;
                slot_reg    <= (ram_rdata.valid && !key_hit) ? slot_reg + 1'b1 : slot_reg;
            end
            S_GAP:
            begin
                diff_reg <= alu_rsp.res;
                gt_reg   <= alu_rsp.cout && (alu_rsp.res != 64'd0);
            end
            S_GAP2:
            begin
                newflow_reg <= timeout_en_reg &&
                               (!ent_reg.time_valid || (gt_reg && !alu_rsp.cout));
            end
            S_SIZE:
            begin
                size_reg <= size_base;
                ok_reg   <= ok_base;
                if (newflow_reg)
                begin
                    ent_reg.valid       <= 1'b1;
                    ent_reg.addrs       <= key_addrs;
                    ent_reg.proto_ports <= key_pp;
                    ent_reg.flow_number <= next_flow_reg;
                    ent_reg.time_valid  <= 1'b0;
                    ent_reg.last_seq    <= 32'd0;
                end
            end
            S_TCP_END:
            begin
                endb_reg <= alu_rsp.res[31:0];
            end
            S_TCP_DEC:
            begin
                endb_reg <= alu_rsp.res[31:0];
                if (!ent_reg.time_valid)
                begin
                    ent_reg.last_seq <= alu_rsp.res[31:0];
                end
            end
            S_TCP_LIM:
            begin
                lim_reg <= alu_rsp.res[31:0];
            end
            S_TCP_D1, S_TCP_D2:
            begin
                d_reg <= alu_rsp.res[31:0];
            end
            S_TCP_C1:
            begin
                if (alu_rsp.cout)
                begin
                    size_reg         <= d_reg[15:0];
                    ent_reg.last_seq <= endb_reg;
                end
            end
            S_TCP_MAG:
            begin
                mag_reg <= ent_reg.last_seq[31] ? alu_rsp.res[31:0] : ent_reg.last_seq;
            end
            S_TCP_C2:
            begin
                if (alu_rsp.cout)
                begin
                    size_reg         <= d_reg[15:0];
                    ent_reg.last_seq <= endb_reg;
                end
                else
                begin
                    size_reg <= 16'd0;
                end
            end
            S_DECIDE:
            begin
                pkt_reg <= ok_reg && (size_reg >= min_size_reg);
                if (ok_reg && (size_reg >= min_size_reg))
                begin
                    ent_reg.seen_time  <= now_reg;
                    ent_reg.time_valid <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (load_full || load_flow)
        begin
            out_reg              <= '0;
            out_reg.kind         <= load_full ? KIND_FULL : KIND_FLOW;
            out_reg.flow_number  <= load_full ? 32'd0 : ent_reg.flow_number;
            out_reg.rec_proto    <= in_reg.proto;
            out_reg.rec_src_ip   <= in_reg.src_ip;
            out_reg.rec_dst_ip   <= in_reg.dst_ip;
            out_reg.rec_src_port <= sp;
            out_reg.rec_dst_port <= dp;
            out_reg.last         <= load_full || !pkt_reg;
        end
        else if (load_pkt)
        begin
            out_reg             <= '0;
            out_reg.kind        <= KIND_PKT;
            out_reg.flow_number <= ent_reg.flow_number;
            out_reg.out_sec     <= sec_reg;
            out_reg.out_usec    <= usec_reg;
            out_reg.out_size    <= size_reg;
            out_reg.last        <= 1'b1;
        end
    end

    `FTPS_ASSERT_IMP(a_ready_no_out, clk, rst_n, in_ch.ready, !out_ch.valid)
    `FTPS_ASSERT_IMP(a_full_last, clk, rst_n,
                     out_ch.valid && out_ch.data.kind == KIND_FULL, out_ch.data.last)
    `FTPS_ASSERT_NXT(a_flow_count, clk, rst_n, state_reg == S_SIZE && newflow_reg,
                     next_flow_reg == $past(next_flow_reg) + 32'd1)

endmodule
